// ===== hdl/itra_pkg.sv =====
// Shared types, constants and the digit-to-character function of the integer to radix text unit.
`default_nettype none
package itra_pkg;

  localparam int VALUE_BITS = 32;                 // width of the converted integer
  localparam int IN_W       = 32;                 // width of the value_bits field
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int STEPS      = 8;                  // quotient bits retired per cycle
  localparam int DIV_CYC    = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int DIV_W      = DIV_CYC * STEPS;    // dividend padded to whole chunks
  localparam int STEP_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int DIG_AW     = $clog2(VALUE_BITS); // digit stack address
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIG_W      = 6;                  // one digit value, 0 to 35

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_DASH   = 8'h2d;
  localparam logic [CHAR_W-1:0]  CHAR_NONE   = 8'h00;

  typedef struct packed {
    logic [IN_W-1:0] value_bits;
    logic            is_signed;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              empty_res;
    logic              last;
  } out_res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic prime;
    logic emit_dash;
    logic emit_digit;
    logic emit_empty;
  } itra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic radix_ok;
    logic q_zero;
    logic neg;
    logic ptr_zero;
  } itra_sts_t;

  // Digit value to lower-case ASCII: 0-9 then a-z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    begin
      if (d < DIG_W'(10)) begin
        c = 8'h30 + CHAR_W'(d);
      end else if (d < DIG_W'(36)) begin
        c = 8'h61 + CHAR_W'(d - DIG_W'(10));
      end else begin
        c = CHAR_NONE;
      end
      return c;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/itra_ctrl.sv =====
// Sequencer of the conversion: division rounds, digit stores and character emission.
`default_nettype none
module itra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire itra_pkg::itra_sts_t sts,
  output itra_pkg::itra_cmd_t     cmd
);
  import itra_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_PRIME = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!sts.radix_ok) begin
            cmd.emit_empty = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_CYC - 1)) begin
          state_nxt = ST_STORE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.q_zero ? ST_PRIME : ST_DIV;
      end
      ST_PRIME: begin
        cmd.prime     = 1'b1;
        cmd.emit_dash = sts.neg;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (sts.ptr_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/itra_dp.sv =====
// Datapath: magnitude, chunked long division, digit stack and result register.
`default_nettype none
module itra_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [itra_pkg::RADIX_W-1:0] radix,
  input  wire itra_pkg::in_req_t        in_req,
  input  wire itra_pkg::itra_cmd_t      cmd,
  output itra_pkg::itra_sts_t           sts,
  output logic                          out_strobe,
  output itra_pkg::out_res_t            out_res
);
  import itra_pkg::*;

  logic [DIV_W-1:0]   mag_r;
  logic [DIG_W-1:0]   rem_r;
  logic               neg_r;
  logic [CNT_W-1:0]   nd_r;
  logic [DIG_AW-1:0]  ptr_r;
  logic [DIG_W-1:0]   rd_data_r;
  logic               out_strobe_r;
  out_res_t           out_res_r;
  logic [DIG_W-1:0]   dig_mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] raw;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [DIV_W-1:0]      div_mag;
  logic [DIG_W:0]        div_rem;
  logic [DIG_AW-1:0]     rd_addr;

  assign raw    = in_req.value_bits[VALUE_BITS-1:0];
  assign neg_in = in_req.is_signed & raw[VALUE_BITS-1];
  // Two's complement negate; the most negative value wraps to its exact magnitude.
  assign mag_in = neg_in ? (~raw + VALUE_BITS'(1)) : raw;

  // One chunk of restoring division: shift in a dividend bit, subtract when it fits.
  always_comb begin
    div_mag = mag_r;
    div_rem = {1'b0, rem_r};
    for (int k = 0; k < STEPS; k++) begin
      div_rem = {div_rem[DIG_W-1:0], div_mag[DIV_W-1]};
      div_mag = {div_mag[DIV_W-2:0], 1'b0};
      if (div_rem >= {1'b0, radix}) begin
        div_rem    = div_rem - {1'b0, radix};
        div_mag[0] = 1'b1;
      end
    end
  end

  assign rd_addr = cmd.prime ? DIG_AW'(nd_r - CNT_W'(1)) : (ptr_r - DIG_AW'(1));

  assign sts.radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign sts.q_zero   = (mag_r == '0);
  assign sts.neg      = neg_r;
  assign sts.ptr_zero = (ptr_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= DIV_W'(mag_in);
      rem_r <= '0;
      neg_r <= neg_in;
      nd_r  <= '0;
    end else if (cmd.div_step) begin
      mag_r <= div_mag;
      rem_r <= div_rem[DIG_W-1:0];
    end else if (cmd.store) begin
      rem_r <= '0;
      nd_r  <= nd_r + CNT_W'(1);
    end
    if (cmd.prime) begin
      ptr_r <= rd_addr;
    end else if (cmd.emit_digit && !sts.ptr_zero) begin
      ptr_r <= rd_addr;
    end
  end

  // Digit stack, least significant digit first.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      dig_mem[nd_r[DIG_AW-1:0]] <= rem_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= dig_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_dash | cmd.emit_digit | cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_res_r.char_code <= CHAR_NONE;
      out_res_r.empty_res <= 1'b1;
      out_res_r.last      <= 1'b1;
    end else if (cmd.emit_dash) begin
      out_res_r.char_code <= CHAR_DASH;
      out_res_r.empty_res <= 1'b0;
      out_res_r.last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_res_r.char_code <= digit_char(rd_data_r);
      out_res_r.empty_res <= 1'b0;
      out_res_r.last      <= sts.ptr_zero;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire

// ===== hdl/integer_to_radix_ascii_unit.sv =====
// Top level of the integer to radix text unit: configuration register and core.
`default_nettype none
// Converts one integer per request into ASCII text in the programmed radix (2 to 36),
// most significant character first: '-' for a negative signed value, then the digits
// 0-9 and a-z, with last set on the final character. A radix outside 2 to 36 gives
// one result with empty_res and last set and no character. A request is taken when
// start is high and busy is low. Each result is valid on out_res for exactly one
// cycle while out_strobe is high; the receiver cannot stall, so capture every
// strobe. Timing: an invalid radix answers in the cycle after the request and busy
// never rises. Otherwise busy stays high through division and emission. The long
// division unit retires 8 quotient bits per cycle; each digit takes one division
// pass over the padded dividend, then a push on the digit stack, and the characters
// then stream out one per cycle from the stack. Write the radix register (address 0)
// only while idle.
module integer_to_radix_ascii_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire itra_pkg::in_req_t  in_req,
  // result channel
  output logic                    out_strobe,
  output itra_pkg::out_res_t      out_res,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import itra_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic               cfg_wr;
  itra_cmd_t          cmd;
  itra_sts_t          sts;

  // Register 0 is the radix; the upper word is unmapped and drops writes.
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - RADIX_W){1'b0}}, radix_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  itra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  itra_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix_r),
    .in_req     (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
`default_nettype wire
